// ===== hw/rtl/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilevel row shear package
// Shared constants, register indexes and the per-item plan structure.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int unsigned MAX_ROW_BYTES = 4096;
  localparam int unsigned MAX_PAD_BYTES = 62;
  localparam int unsigned RESULT_LIMIT  = 64;

  localparam int unsigned CNT_W   = 7;   // holds 0..RESULT_LIMIT and candidate counts
  localparam int unsigned LEAD_W  = 6;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned STEP_W  = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LEN_W-1:0]  ROW_LEN_CAP = LEN_W'(MAX_ROW_BYTES + MAX_PAD_BYTES);
  localparam logic [LEAD_W-1:0] LEAD_CEIL   = LEAD_W'(MAX_PAD_BYTES);
  localparam logic [CNT_W-1:0]  RES_LIMIT   = CNT_W'(RESULT_LIMIT);
  // Tail byte plus the longest padding run.
  localparam logic [CNT_W-1:0]  END_EXTRA   = CNT_W'(MAX_PAD_BYTES + 1);
  localparam logic [7:0]        WHITE       = 8'hFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NEW_ROW_BYTES = CFG_IDX_W'(1);

  // Everything the result sequencer needs to expand one input item.
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;       // number of result items, 0..64
    logic [LEAD_W-1:0] lead_pos;  // position of the data byte in the sequence
    logic [7:0]        data;      // shifted source byte with carried bits
    logic [7:0]        tail;      // closing byte of the row
    logic              row_flag;  // last result also closes the output row
  } plan_t;

endpackage

// ===== hw/rtl/brs_row_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bilevel row shear row control
// Holds the shear state and configuration and plans the results of one item.
// ----------------------------------------------------------------------------
module brs_row_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [7:0]                      pixel_byte,
  input  logic                            row_end,
  input  logic                            cfg_we,
  input  logic [brs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output brs_pkg::plan_t                  plan
);

  logic [brs_pkg::STEP_W-1:0] rows_per_step_r;
  logic [brs_pkg::LEN_W-1:0]  new_row_bytes_r;
  logic [2:0]                 bit_shift_r;
  logic [brs_pkg::LEAD_W-1:0] lead_bytes_r;
  logic [brs_pkg::STEP_W-1:0] step_countdown_r;
  logic [7:0]                 carry_bits_r;
  logic                       in_row_r;
  logic [brs_pkg::LEN_W-1:0]  out_count_r;

  logic                       row_start;
  logic [7:0]                 carry_cur;
  logic [15:0]                shifted;
  logic [brs_pkg::LEN_W-1:0]  row_len;
  logic [brs_pkg::LEN_W-1:0]  room;
  logic [brs_pkg::CNT_W-1:0]  cand;
  logic [brs_pkg::CNT_W-1:0]  cand_lim;
  logic [brs_pkg::CNT_W-1:0]  cnt;
  logic [brs_pkg::LEAD_W-1:0] lead_pos;
  logic [brs_pkg::STEP_W-1:0] countdown_dec;
  logic [brs_pkg::STEP_W-1:0] reload;
  logic [brs_pkg::STEP_W-1:0] half_cfg;
  logic                       at_ceiling;

  assign row_start = !in_row_r;
  assign carry_cur = row_start ? ~(brs_pkg::WHITE >> bit_shift_r) : carry_bits_r;
  assign shifted   = {pixel_byte, 8'h00} >> bit_shift_r;
  assign lead_pos  = row_start ? lead_bytes_r : '0;

  assign row_len = (new_row_bytes_r < brs_pkg::ROW_LEN_CAP) ? new_row_bytes_r
                                                             : brs_pkg::ROW_LEN_CAP;
  assign room    = (row_len > out_count_r) ? (row_len - out_count_r) : '0;

  // Candidate bytes: lead fill, the data byte, and at row end the tail and padding.
  assign cand     = brs_pkg::CNT_W'(lead_pos) + brs_pkg::CNT_W'(1)
                  + (row_end ? brs_pkg::END_EXTRA : '0);
  assign cand_lim = (cand > brs_pkg::RES_LIMIT) ? brs_pkg::RES_LIMIT : cand;
  assign cnt      = (room < brs_pkg::LEN_W'(cand_lim)) ? room[brs_pkg::CNT_W-1:0] : cand_lim;

  always_comb begin
    plan.cnt      = cnt;
    plan.lead_pos = lead_pos;
    plan.data     = carry_cur | shifted[15:8];
    plan.tail     = shifted[7:0] | (brs_pkg::WHITE >> bit_shift_r);
    plan.row_flag = row_end || (brs_pkg::LEN_W'(cnt) == room);
  end

  assign countdown_dec = step_countdown_r - brs_pkg::STEP_W'(1);
  assign reload        = (rows_per_step_r == '0) ? brs_pkg::STEP_W'(1) : rows_per_step_r;
  assign half_cfg      = (cfg_data[brs_pkg::CFG_DATA_W-1:1] == '0) ? brs_pkg::STEP_W'(1)
                       : brs_pkg::STEP_W'(cfg_data[brs_pkg::CFG_DATA_W-1:1]);
  assign at_ceiling    = (lead_bytes_r >= brs_pkg::LEAD_CEIL) && (bit_shift_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_per_step_r  <= brs_pkg::STEP_W'(1);
      new_row_bytes_r  <= brs_pkg::LEN_W'(1);
      bit_shift_r      <= '0;
      lead_bytes_r     <= '0;
      step_countdown_r <= brs_pkg::STEP_W'(1);
      carry_bits_r     <= '0;
      in_row_r         <= 1'b0;
      out_count_r      <= '0;
    end else begin
      if (accept) begin
        in_row_r     <= !row_end;
        carry_bits_r <= row_end ? 8'h00 : shifted[7:0];
        out_count_r  <= row_end ? '0 : (out_count_r + brs_pkg::LEN_W'(cnt));
        if (row_end) begin
          if (countdown_dec == '0) begin
            step_countdown_r <= reload;
            if (!at_ceiling) begin
              if (bit_shift_r == 3'd7) begin
                bit_shift_r  <= '0;
                lead_bytes_r <= lead_bytes_r + brs_pkg::LEAD_W'(1);
              end else begin
                bit_shift_r <= bit_shift_r + 3'd1;
              end
            end
          end else begin
            step_countdown_r <= countdown_dec;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == brs_pkg::REG_ROWS_PER_STEP) begin
          rows_per_step_r  <= cfg_data;
          step_countdown_r <= half_cfg;
        end else if (cfg_index == brs_pkg::REG_NEW_ROW_BYTES) begin
          new_row_bytes_r <= cfg_data[brs_pkg::LEN_W-1:0];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/bilevel_row_shear_core.sv =====
// ----------------------------------------------------------------------------
// Bilevel row shear core
// Horizontal shear of a 1-bit-per-pixel image streamed one byte per item.
// ----------------------------------------------------------------------------
// Each accepted source byte expands into zero or more output items, one per
// cycle while out_stall is low: at the start of a row the whole white lead
// bytes come first, then the source byte shifted right by the current bit
// offset, and at the end of a row the tail byte and up to 62 white padding
// bytes, cut off at the output row length. A byte in the middle of a row makes
// at most one item, so such bytes stream at one per cycle while out_stall is
// low; a row-start or row-end byte makes up to 64 items, and in_stall stays
// high while they drain through the result sequencer. An item that makes no
// result (row already full) leaves the sequencer empty and does not stall.
// Results pass through the sequencer register and then the output register.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while no item is in flight.
module bilevel_row_shear_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // Source byte channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_pixel_byte,
  input  logic                            in_row_end,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_out_byte,
  output logic                            out_run_last,
  output logic                            out_row_last,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [brs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  brs_pkg::plan_t              plan;
  brs_pkg::plan_t              gen_plan_r;
  logic                        gen_valid_r;
  logic [brs_pkg::CNT_W-1:0]   gen_idx_r;

  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic                        out_run_last_r;
  logic                        out_row_last_r;

  logic                        in_acc;
  logic                        out_adv;
  logic                        gen_last;
  logic [brs_pkg::CNT_W-1:0]   lead_pos_ext;
  logic [7:0]                  gen_byte;

  assign cfg_ready = 1'b1;

  brs_row_ctrl u_row_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_acc),
    .pixel_byte (in_pixel_byte),
    .row_end    (in_row_end),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .plan       (plan)
  );

  // The output register moves whenever it is empty or being taken.
  assign out_adv  = !out_valid_r || !out_stall;
  assign gen_last = (gen_idx_r + brs_pkg::CNT_W'(1)) == gen_plan_r.cnt;

  // A new item enters the sequencer as the previous one hands over its last result.
  assign in_stall = gen_valid_r && !(out_adv && gen_last);
  assign in_acc   = in_valid && !in_stall;

  // Byte at the current position: white lead, data, tail, then white padding.
  assign lead_pos_ext = brs_pkg::CNT_W'(gen_plan_r.lead_pos);
  always_comb begin
    if (gen_idx_r == lead_pos_ext) begin
      gen_byte = gen_plan_r.data;
    end else if (gen_idx_r == lead_pos_ext + brs_pkg::CNT_W'(1)) begin
      gen_byte = gen_plan_r.tail;
    end else begin
      gen_byte = brs_pkg::WHITE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_valid_r <= 1'b0;
      gen_idx_r   <= '0;
    end else if (in_acc) begin
      gen_valid_r <= (plan.cnt != '0);
      gen_idx_r   <= '0;
    end else if (gen_valid_r && out_adv) begin
      if (gen_last) begin
        gen_valid_r <= 1'b0;
      end else begin
        gen_idx_r <= gen_idx_r + brs_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      gen_plan_r <= plan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= gen_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && gen_valid_r) begin
      out_byte_r     <= gen_byte;
      out_run_last_r <= gen_last;
      out_row_last_r <= gen_last && gen_plan_r.row_flag;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_out_byte = out_byte_r;
  assign out_run_last = out_run_last_r;
  assign out_row_last = out_row_last_r;

`ifndef ASSERT_OFF
  // An item only enters while the sequencer is empty or finishing.
  a_accept_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && gen_valid_r) |-> (out_adv && gen_last))
    else $error("item accepted while results still pending");

  // The sequencer position stays inside the planned result count.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    gen_valid_r |-> ((gen_idx_r < gen_plan_r.cnt) && (gen_plan_r.cnt <= brs_pkg::RES_LIMIT)))
    else $error("result index outside planned count");

  // A pending result always reaches an empty output register in the next cycle.
  a_gen_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("pending result did not reach the output register");

  // Row end marking is only ever placed on the last result of an item.
  a_row_last_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_row_last_r) |-> out_run_last_r)
    else $error("row end marked on a result that is not the last of its item");
`endif

endmodule
